FILE: design/cht_pkg.sv
`timescale 1ns / 1ps
package cht_pkg;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_FIND   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  localparam int unsigned HashOne = 269;
  localparam int unsigned HashTwo = 271;
  localparam int unsigned KickReset = 1024;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_LOOK  = 8'b00000010,
    S_CHECK = 8'b00000100,
    S_RD1   = 8'b00001000,
    S_WR1   = 8'b00010000,
    S_RD2   = 8'b00100000,
    S_WR2   = 8'b01000000,
    S_CLEAR = 8'b10000000
  } state_e;

endpackage

FILE: design/cht_hash.sv
`timescale 1ns / 1ps
module cht_hash
  import cht_pkg::*;
#(
  parameter int unsigned IndexBits = 10,
  parameter int unsigned KeyBits   = 32
) (
  input  logic [KeyBits-1:0]   key_i,
  output logic [IndexBits-1:0] slot_one_o,
  output logic [IndexBits-1:0] slot_two_o
);

  localparam int unsigned W = (KeyBits < IndexBits) ? KeyBits : IndexBits;

  logic [IndexBits-1:0] key_low;
  logic [IndexBits-1:0] m1;
  logic [IndexBits-1:0] m2;

  assign m1 = IndexBits'(HashOne);
  assign m2 = IndexBits'(HashTwo);

  always_comb begin
    key_low = '0;
    key_low[W-1:0] = key_i[W-1:0];
  end

  assign slot_one_o = IndexBits'(key_low * m1);
  assign slot_two_o = IndexBits'(key_low * m2);

endmodule

FILE: design/cuckoo_hash_table.sv
`timescale 1ns / 1ps
// channel | signals                                         | direction
// in      | in_valid_i in_ready_o mode_i key_i value_i      | in
// out     | out_valid_o out_ready_i status_o value_out_o    | out
//         | homeless_key_o homeless_value_o entry_count_o   |
// cfg     | cfg_we_i cfg_data_i (kick_limit)                | in
// Find, delete, unused mode, duplicate and zero-limit inserts pass S_LOOK and
// S_CHECK, which registers the result; the next transfer waits for S_IDLE.
// An insert goes on to S_WR1 and places further keys via S_RD2/S_WR2 and
// S_RD1/S_WR1; a full table stops after kick_limit rounds. One port per table.
// After reset a pass over all 2^INDEX_BITS slots (1024) zeroes the valid bits.
// A held result blocks the next item only until it is taken.
module cuckoo_hash_table
  import cht_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 10,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] value_out_o,
  output logic [31:0] homeless_key_o,
  output logic [31:0] homeless_value_o,
  output logic [11:0] entry_count_o
);

  localparam int unsigned Slots = 1 << INDEX_BITS;
  localparam int unsigned KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int unsigned VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int unsigned CntBits = INDEX_BITS + 2;

  logic [KEY_BITS-1:0]   keys_one [Slots];
  logic [VALUE_BITS-1:0] vals_one [Slots];
  logic [KEY_BITS-1:0]   keys_two [Slots];
  logic [VALUE_BITS-1:0] vals_two [Slots];
  logic                  vld_one [Slots];
  logic                  vld_two [Slots];

  state_e state_q;
  logic [1:0] mode_q;
  logic [KEY_BITS-1:0] ck_q;
  logic [VALUE_BITS-1:0] cv_q;
  logic [15:0] kick_q, round_q;
  logic [CntBits-1:0] count_q;
  logic [INDEX_BITS-1:0] a_q, b_q;
  logic [INDEX_BITS-1:0] clr_q;
  logic [KEY_BITS-1:0] rk1_q, rk2_q;
  logic [VALUE_BITS-1:0] rv1_q, rv2_q;
  logic rvl1_q, rvl2_q;
  logic out_valid_q;
  logic [1:0] status_q;
  logic [31:0] vout_q, hk_q, hv_q;

  logic [KEY_BITS-1:0] key_in;
  logic [VALUE_BITS-1:0] val_in;
  logic [INDEX_BITS-1:0] h1, h2;

  always_comb begin
    key_in = '0;
    key_in[KW-1:0] = key_i[KW-1:0];
    val_in = '0;
    val_in[VW-1:0] = value_i[VW-1:0];
  end

  cht_hash #(.IndexBits(INDEX_BITS), .KeyBits(KEY_BITS)) u_hash (
    .key_i     (state_q == S_IDLE ? key_in : ck_q),
    .slot_one_o(h1),
    .slot_two_o(h2)
  );

  logic in_fire, in_one, in_two;
  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign in_fire = in_valid_i && in_ready_o;
  assign in_one = rvl1_q && (rk1_q == ck_q);
  assign in_two = rvl2_q && (rk2_q == ck_q);

  logic we1, we2;
  logic [INDEX_BITS-1:0] wa1, wa2;
  assign we1 = (state_q == S_WR1);
  assign we2 = (state_q == S_WR2);
  assign wa1 = a_q;
  assign wa2 = b_q;

  logic [INDEX_BITS-1:0] ra1, ra2;
  assign ra1 = (state_q == S_RD1) ? h1 : a_q;
  assign ra2 = (state_q == S_RD2) ? h2 : b_q;

  logic del_one, del_two;
  logic vwe1, vwe2;
  logic [INDEX_BITS-1:0] va1, va2;
  assign del_one = (state_q == S_CHECK) && (mode_q == MODE_DELETE) && in_one;
  assign del_two = (state_q == S_CHECK) && (mode_q == MODE_DELETE) && !in_one && in_two;
  assign vwe1 = (state_q == S_CLEAR) || we1 || del_one;
  assign vwe2 = (state_q == S_CLEAR) || we2 || del_two;
  assign va1 = (state_q == S_CLEAR) ? clr_q : a_q;
  assign va2 = (state_q == S_CLEAR) ? clr_q : b_q;

  always_ff @(posedge clk_i) begin
    if (we1) begin
      keys_one[wa1] <= ck_q;
      vals_one[wa1] <= cv_q;
    end
    if (vwe1) vld_one[va1] <= we1;
    rk1_q  <= keys_one[ra1];
    rv1_q  <= vals_one[ra1];
    rvl1_q <= vld_one[ra1];
  end

  always_ff @(posedge clk_i) begin
    if (we2) begin
      keys_two[wa2] <= ck_q;
      vals_two[wa2] <= cv_q;
    end
    if (vwe2) vld_two[va2] <= we2;
    rk2_q  <= keys_two[ra2];
    rv2_q  <= vals_two[ra2];
    rvl2_q <= vld_two[ra2];
  end

  function automatic logic [31:0] k32(logic [KEY_BITS-1:0] k);
    logic [31:0] r;
    r = '0;
    r[KW-1:0] = k[KW-1:0];
    return r;
  endfunction

  function automatic logic [31:0] v32(logic [VALUE_BITS-1:0] v);
    logic [31:0] r;
    r = '0;
    r[VW-1:0] = v[VW-1:0];
    return r;
  endfunction

  status_e chk_status;
  logic [31:0] chk_vout, chk_hk, chk_hv;
  logic chk_go;

  always_comb begin
    chk_status = ST_NOT_FOUND;
    chk_vout = '0;
    chk_hk = '0;
    chk_hv = '0;
    chk_go = 1'b0;
    case (mode_q)
      MODE_INSERT: begin
        if (in_one || in_two) begin
          chk_status = ST_DUPLICATE;
        end else if (kick_q == '0) begin
          chk_status = ST_FULL;
          chk_hk = k32(ck_q);
          chk_hv = v32(cv_q);
        end else begin
          chk_go = 1'b1;
        end
      end
      MODE_DELETE, MODE_FIND: begin
        if (in_one) begin
          chk_status = ST_OK;
          chk_vout = v32(rv1_q);
        end else if (in_two) begin
          chk_status = ST_OK;
          chk_vout = v32(rv2_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      kick_q      <= 16'(KickReset);
      count_q     <= '0;
      out_valid_q <= 1'b0;
      round_q     <= '0;
    end else begin
      if (cfg_we_i) kick_q <= cfg_data_i;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == INDEX_BITS'(Slots - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_fire) begin
            mode_q  <= mode_i;
            ck_q    <= key_in;
            cv_q    <= val_in;
            a_q     <= h1;
            b_q     <= h2;
            round_q <= '0;
            state_q <= S_LOOK;
          end
        end
        S_LOOK: state_q <= S_CHECK;
        S_CHECK: begin
          status_q <= chk_status;
          vout_q   <= chk_vout;
          hk_q     <= chk_hk;
          hv_q     <= chk_hv;
          if (chk_go) begin
            state_q <= S_WR1;
          end else begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
          end
          if (del_one || del_two) count_q <= count_q - 1'b1;
        end
        S_RD1: begin
          a_q <= h1;
          state_q <= S_WR1;
        end
        S_WR1: begin
          // write into slot a_q; rk1/rvl1 valid from read issued previous cycle
          if (!rvl1_q) begin
            count_q <= count_q + 1'b1;
            status_q <= ST_OK;
            vout_q <= '0; hk_q <= '0; hv_q <= '0;
            out_valid_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            ck_q <= rk1_q;
            cv_q <= rv1_q;
            state_q <= S_RD2;
          end
        end
        S_RD2: begin
          b_q <= h2;
          state_q <= S_WR2;
        end
        S_WR2: begin
          if (!rvl2_q) begin
            count_q <= count_q + 1'b1;
            status_q <= ST_OK;
            vout_q <= '0; hk_q <= '0; hv_q <= '0;
            out_valid_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            ck_q <= rk2_q;
            cv_q <= rv2_q;
            if (round_q + 16'd1 >= kick_q) begin
              status_q <= ST_FULL;
              vout_q <= '0;
              hk_q <= k32(rk2_q);
              hv_q <= v32(rv2_q);
              out_valid_q <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              round_q <= round_q + 16'd1;
              state_q <= S_RD1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign value_out_o      = vout_q;
  assign homeless_key_o   = hk_q;
  assign homeless_value_o = hv_q;
  assign entry_count_o    = 12'(count_q);

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !in_ready_o) else $error("accept while result held");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(2 * Slots)) else $error("count overflow");
  a_result_after_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_CHECK || $past(state_q) == S_WR1
      || $past(state_q) == S_WR2)) else $error("result from wrong state");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import cht_pkg::*;

  localparam int unsigned Slots = 1024;
  localparam int unsigned IdleLimit = 1500000;

  typedef struct packed {
    status_e     status;
    logic [31:0] value_out;
    logic [31:0] homeless_key;
    logic [31:0] homeless_value;
    logic [11:0] entry_count;
  } result_t;

  typedef struct {
    bit          is_cfg;
    logic [15:0] kick;
    mode_e       mode;
    logic [31:0] key;
    logic [31:0] value;
    bit          typed;
    result_t     res;
  } row_t;

  typedef struct {
    logic [15:0] kick;
    bit          pooled;
    int          items;
  } phase_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = MODE_FIND;
  logic [31:0] key_i = '0;
  logic [31:0] value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] value_out_o;
  logic [31:0] homeless_key_o;
  logic [31:0] homeless_value_o;
  logic [11:0] entry_count_o;

  logic [31:0] t1_key [Slots];
  logic [31:0] t1_val [Slots];
  bit          t1_used [Slots];
  logic [31:0] t2_key [Slots];
  logic [31:0] t2_val [Slots];
  bit          t2_used [Slots];
  int unsigned pairs_held;
  logic [15:0] kick_limit;

  result_t     pending_results [$];
  row_t        dir_rows [$];
  logic [31:0] group_base [8];
  int          fails = 0;
  int          burst_left = 0;
  bit          hold_req = 1'b0;
  int unsigned quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  cuckoo_hash_table u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .key_i            (key_i),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .value_out_o      (value_out_o),
    .homeless_key_o   (homeless_key_o),
    .homeless_value_o (homeless_value_o),
    .entry_count_o    (entry_count_o)
  );

  function automatic logic [9:0] slot_one(logic [31:0] k);
    logic [31:0] p;
    p = k * HashOne;
    return p[9:0];
  endfunction

  function automatic logic [9:0] slot_two(logic [31:0] k);
    logic [31:0] p;
    p = k * HashTwo;
    return p[9:0];
  endfunction

  function automatic result_t apply_op(mode_e m, logic [31:0] k, logic [31:0] v);
    result_t     r;
    logic [9:0]  a, b, s;
    bit          hit1, hit2, placed;
    logic [31:0] ck, cv, tk, tv;
    a = slot_one(k);
    b = slot_two(k);
    hit1 = t1_used[a] && t1_key[a] == k;
    hit2 = t2_used[b] && t2_key[b] == k;
    r = '{ST_NOT_FOUND, 32'd0, 32'd0, 32'd0, 12'd0};
    case (m)
      MODE_INSERT: begin
        if (hit1 || hit2) begin
          r.status = ST_DUPLICATE;
        end else begin
          ck = k;
          cv = v;
          placed = 1'b0;
          for (int unsigned n = 0; n < kick_limit && !placed; n++) begin
            s = slot_one(ck);
            if (!t1_used[s]) begin
              t1_key[s] = ck;
              t1_val[s] = cv;
              t1_used[s] = 1'b1;
              placed = 1'b1;
            end else begin
              tk = t1_key[s];
              tv = t1_val[s];
              t1_key[s] = ck;
              t1_val[s] = cv;
              ck = tk;
              cv = tv;
              s = slot_two(ck);
              if (!t2_used[s]) begin
                t2_key[s] = ck;
                t2_val[s] = cv;
                t2_used[s] = 1'b1;
                placed = 1'b1;
              end else begin
                tk = t2_key[s];
                tv = t2_val[s];
                t2_key[s] = ck;
                t2_val[s] = cv;
                ck = tk;
                cv = tv;
              end
            end
          end
          if (placed) begin
            pairs_held++;
            r.status = ST_OK;
          end else begin
            r.status = ST_FULL;
            r.homeless_key = ck;
            r.homeless_value = cv;
          end
        end
      end
      MODE_DELETE, MODE_FIND: begin
        if (hit1) begin
          r.value_out = t1_val[a];
          r.status = ST_OK;
          if (m == MODE_DELETE) begin
            t1_used[a] = 1'b0;
            pairs_held--;
          end
        end else if (hit2) begin
          r.value_out = t2_val[b];
          r.status = ST_OK;
          if (m == MODE_DELETE) begin
            t2_used[b] = 1'b0;
            pairs_held--;
          end
        end
      end
      default: ;
    endcase
    r.entry_count = pairs_held[11:0];
    return r;
  endfunction

  task automatic send_item(mode_e m, logic [31:0] k, logic [31:0] v, bit typed,
                           result_t given);
    result_t r;
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    in_valid_i = 1'b1;
    mode_i = m;
    key_i = k;
    value_i = v;
    do @(posedge clk_i); while (!in_ready_o);
    r = apply_op(m, k, v);
    pending_results.push_back(typed ? given : r);
    @(negedge clk_i);
    burst_left--;
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_kick(logic [15:0] k);
    drain_results();
    cfg_we_i = 1'b1;
    cfg_data_i = k;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    kick_limit = k;
  endtask

  function automatic logic [31:0] pick_key(bit pooled);
    if (pooled && $urandom_range(0, 9) < 8) begin
      return group_base[$urandom_range(0, 7)] + 32'd1024 * $urandom_range(0, 5);
    end
    return $urandom();
  endfunction

  function automatic mode_e pick_mode();
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 45) return MODE_INSERT;
    if (w < 70) return MODE_FIND;
    if (w < 96) return MODE_DELETE;
    return MODE_NONE;
  endfunction

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (400) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (($urandom_range(0, 255) & 8'h80) != 0) begin
        out_ready_i = 1'b1;
      end else begin
        out_ready_i = $urandom_range(0, 2) != 0;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t e;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles > IdleLimit) begin
      $display("tb failed");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation waiting");
        fails++;
      end else begin
        e = pending_results.pop_front();
        if (status_o !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, status_o);
          fails++;
        end
        if (value_out_o !== e.value_out) begin
          $error("value_out: expected %h, actual %h", e.value_out, value_out_o);
          fails++;
        end
        if (homeless_key_o !== e.homeless_key) begin
          $error("homeless_key: expected %h, actual %h", e.homeless_key, homeless_key_o);
          fails++;
        end
        if (homeless_value_o !== e.homeless_value) begin
          $error("homeless_value: expected %h, actual %h", e.homeless_value,
                 homeless_value_o);
          fails++;
        end
        if (entry_count_o !== e.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", e.entry_count, entry_count_o);
          fails++;
        end
      end
    end
  end

  initial begin
    phase_t  phases [7];
    result_t none_r;
    none_r = '{ST_OK, 32'd0, 32'd0, 32'd0, 12'd0};
    for (int i = 0; i < Slots; i++) begin
      t1_used[i] = 1'b0;
      t2_used[i] = 1'b0;
    end
    pairs_held = 0;
    kick_limit = KickReset;
    for (int i = 0; i < 8; i++) group_base[i] = $urandom();

    dir_rows.push_back('{0, 0, MODE_FIND, 32'd0, 32'd0, 1,
                         '{ST_NOT_FOUND, 32'd0, 32'd0, 32'd0, 12'd0}});
    dir_rows.push_back('{0, 0, MODE_INSERT, 32'd0, 32'd0, 1,
                         '{ST_OK, 32'd0, 32'd0, 32'd0, 12'd1}});
    dir_rows.push_back('{0, 0, MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                         '{ST_OK, 32'd0, 32'd0, 32'd0, 12'd2}});
    dir_rows.push_back('{0, 0, MODE_FIND, 32'hFFFF_FFFF, 32'd0, 1,
                         '{ST_OK, 32'hFFFF_FFFF, 32'd0, 32'd0, 12'd2}});
    dir_rows.push_back('{0, 0, MODE_INSERT, 32'd0, 32'd5, 1,
                         '{ST_DUPLICATE, 32'd0, 32'd0, 32'd0, 12'd2}});
    dir_rows.push_back('{0, 0, MODE_NONE, 32'hDEAD_BEEF, 32'h1234_5678, 1,
                         '{ST_NOT_FOUND, 32'd0, 32'd0, 32'd0, 12'd2}});
    dir_rows.push_back('{0, 0, MODE_DELETE, 32'd0, 32'd0, 1,
                         '{ST_OK, 32'd0, 32'd0, 32'd0, 12'd1}});
    dir_rows.push_back('{0, 0, MODE_DELETE, 32'd0, 32'd0, 1,
                         '{ST_NOT_FOUND, 32'd0, 32'd0, 32'd0, 12'd1}});
    dir_rows.push_back('{1, 16'd1, MODE_FIND, 32'd0, 32'd0, 0, none_r});
    dir_rows.push_back('{0, 0, MODE_INSERT, 32'd7, 32'h1111_1111, 0, none_r});
    dir_rows.push_back('{0, 0, MODE_INSERT, 32'd1031, 32'h2222_2222, 0, none_r});
    dir_rows.push_back('{0, 0, MODE_INSERT, 32'd2055, 32'h3333_3333, 0, none_r});
    dir_rows.push_back('{0, 0, MODE_FIND, 32'd7, 32'd0, 0, none_r});
    dir_rows.push_back('{0, 0, MODE_FIND, 32'd1031, 32'd0, 0, none_r});
    dir_rows.push_back('{0, 0, MODE_FIND, 32'd2055, 32'd0, 0, none_r});
    dir_rows.push_back('{0, 0, MODE_DELETE, 32'd1031, 32'd0, 0, none_r});
    dir_rows.push_back('{0, 0, MODE_DELETE, 32'd2055, 32'd0, 0, none_r});
    dir_rows.push_back('{1, 16'd0, MODE_FIND, 32'd0, 32'd0, 0, none_r});
    dir_rows.push_back('{0, 0, MODE_INSERT, 32'd99, 32'hA5A5_A5A5, 0, none_r});
    dir_rows.push_back('{1, 16'hFFFF, MODE_FIND, 32'd0, 32'd0, 0, none_r});
    dir_rows.push_back('{0, 0, MODE_INSERT, 32'h8000_0000, 32'h5A5A_5A5A, 0, none_r});
    dir_rows.push_back('{0, 0, MODE_DELETE, 32'hFFFF_FFFF, 32'd0, 0, none_r});

    phases[0] = '{16'hFFFF, 1'b0, 80};
    phases[1] = '{16'd1024, 1'b0, 150};
    phases[2] = '{16'd1, 1'b1, 230};
    phases[3] = '{16'd3, 1'b1, 230};
    phases[4] = '{16'd0, 1'b1, 80};
    phases[5] = '{16'd16, 1'b1, 230};
    phases[6] = '{16'd2, 1'b1, 130};

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_kick(dir_rows[i].kick);
      end else begin
        send_item(dir_rows[i].mode, dir_rows[i].key, dir_rows[i].value,
                  dir_rows[i].typed, dir_rows[i].res);
      end
    end

    foreach (phases[p]) begin
      write_kick(phases[p].kick);
      if (p == 3) hold_req = 1'b1;
      for (int n = 0; n < phases[p].items; n++) begin
        send_item(pick_mode(), pick_key(phases[p].pooled), $urandom(), 1'b0, none_r);
      end
    end

    drain_results();
    if (fails == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
